FILE: hdl/tone_noise_sound_generator_assert.svh
// ----------------------------------------------------------------------------
// tone_noise_sound_generator_assert.svh
// Assertion macros for the tone and noise sound generator. The including
// module must provide clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef TONE_NOISE_SOUND_GENERATOR_ASSERT_SVH
`define TONE_NOISE_SOUND_GENERATOR_ASSERT_SVH

// Check cons in the same cycle whenever ante holds.
`define TNSG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tone_noise_sound_generator: same-cycle check failed");

// Check cons in the cycle after ante holds.
`define TNSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tone_noise_sound_generator: next-cycle check failed");

`endif

FILE: hdl/tnsg_pkg.sv
// ----------------------------------------------------------------------------
// tnsg_pkg
// Shared widths, constants, types and codes of the tone and noise generator.
// ----------------------------------------------------------------------------
package tnsg_pkg;

  // Field widths
  localparam int unsigned LATCH_W  = 8;
  localparam int unsigned SAMPLE_W = 15;
  localparam int unsigned RATE_W   = 18;
  localparam int unsigned NOISE_W  = 16;
  localparam int unsigned VCOUNT_W = 7;
  // Signed working width of the rate accumulator
  localparam int unsigned ACC_W    = 20;

  // Rate conversion
  localparam int VCLOCK_RATE  = 12000;
  localparam int MIN_RATE     = 1000;
  localparam int OUT_RATE_RST = 48000;

  // Volume envelope
  localparam logic [SAMPLE_W-1:0] FULL_VOLUME = 15'h7fff;
  localparam logic [SAMPLE_W-1:0] VOLUME_STEP = 15'd8;

  // Input item codes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_LATCH  = 1'b1;

  // Waveform select codes, latch bits 2..0
  typedef enum logic [2:0] {
    WAVE_SQ_V2   = 3'd0,
    WAVE_SQ_V3   = 3'd1,
    WAVE_SQ_V4   = 3'd2,
    WAVE_SQ_V5   = 3'd3,
    WAVE_MIX_V04 = 3'd4,
    WAVE_MIX_V15 = 3'd5,
    WAVE_MIX_V26 = 3'd6,
    WAVE_NOISE   = 3'd7
  } tnsg_wave_e;

  // Rate sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUB,
    ST_TICK
  } tnsg_state_e;

  // Control from the top level and sequencer into the voice
  typedef struct packed {
    logic               latch_we;
    logic [LATCH_W-1:0] latch_data;
    logic               tick;
  } tnsg_voice_ctrl_t;

  // Status from the voice
  typedef struct packed {
    logic [SAMPLE_W-1:0] signal_level;
    logic                halve;
  } tnsg_voice_stat_t;

endpackage

FILE: hdl/tnsg_if.sv
// ----------------------------------------------------------------------------
// tnsg_if
// Valid/ready channels of the generator: request, sample and configuration.
// ----------------------------------------------------------------------------
interface tnsg_req_if;
  import tnsg_pkg::*;

  logic               valid;
  logic               ready;
  logic               mode;
  logic [LATCH_W-1:0] latch_data;

  modport source (output valid, output mode, output latch_data, input ready);
  modport sink   (input valid, input mode, input latch_data, output ready);
endinterface

interface tnsg_smp_if;
  import tnsg_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tnsg_cfg_if;
  import tnsg_pkg::*;

  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] out_rate;

  modport source (output valid, output out_rate, input ready);
  modport sink   (input valid, input out_rate, output ready);
endinterface

FILE: hdl/tnsg_voice.sv
// ----------------------------------------------------------------------------
// tnsg_voice
// Sound latch, vertical counter, waveform select, noise shifter and volume
// envelope. Advances one vertical tick per cycle with tick and no latch_we.
// ----------------------------------------------------------------------------
module tnsg_voice (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tnsg_pkg::tnsg_voice_ctrl_t ctrl_i,
  output tnsg_pkg::tnsg_voice_stat_t stat_o
);
  import tnsg_pkg::*;

  logic [LATCH_W-1:0]  latch_q,  latch_d;
  logic [SAMPLE_W-1:0] signal_q, signal_d;
  logic [SAMPLE_W-1:0] volume_q, volume_d;
  logic [NOISE_W-1:0]  noise_q,  noise_d;
  logic [VCOUNT_W-1:0] vcount_q, vcount_d;
  logic [VCOUNT_W-1:0] vnext;
  logic                on;
  logic                noise_in;
  tnsg_wave_e          wave;

  assign vnext    = vcount_q + VCOUNT_W'(1);
  assign wave     = tnsg_wave_e'(latch_q[2:0]);
  assign noise_in = (noise_q[0] == noise_q[10]);

  // Pick the gate for the current waveform
  always_comb begin
    unique case (wave)
      WAVE_SQ_V2:   on = vnext[2];
      WAVE_SQ_V3:   on = vnext[3];
      WAVE_SQ_V4:   on = vnext[4];
      WAVE_SQ_V5:   on = vnext[5];
      WAVE_MIX_V04: on = !(vnext[0] || vnext[4]);
      WAVE_MIX_V15: on = !(vnext[1] || vnext[5]);
      WAVE_MIX_V26: on = !(vnext[2] || vnext[6]);
      WAVE_NOISE:   on = noise_q[NOISE_W-1];
      default:      on = 1'b0;
    endcase
  end

  // Apply a latch write or one vertical tick
  always_comb begin
    latch_d  = latch_q;
    signal_d = signal_q;
    volume_d = volume_q;
    noise_d  = noise_q;
    vcount_d = vcount_q;
    if (ctrl_i.latch_we) begin
      latch_d  = ctrl_i.latch_data;
      volume_d = FULL_VOLUME;
      noise_d  = '0;
    end else if (ctrl_i.tick) begin
      vcount_d = vnext;
      signal_d = on ? volume_q : '0;
      volume_d = (volume_q > VOLUME_STEP) ? (volume_q - VOLUME_STEP) : '0;
      if ((wave == WAVE_NOISE) && (vnext[1:0] == 2'b10)) begin
        noise_d = {noise_q[NOISE_W-2:0], noise_in};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= '0;
      signal_q <= '0;
      volume_q <= '0;
      noise_q  <= '0;
      vcount_q <= '0;
    end else begin
      latch_q  <= latch_d;
      signal_q <= signal_d;
      volume_q <= volume_d;
      noise_q  <= noise_d;
      vcount_q <= vcount_d;
    end
  end

  assign stat_o.signal_level = signal_q;
  assign stat_o.halve        = latch_q[3];

endmodule

FILE: hdl/tnsg_rate_seq.sv
// ----------------------------------------------------------------------------
// tnsg_rate_seq
// Rate accumulator and sequencer. One shared adder first subtracts the
// vertical clock rate, then adds the sample rate once per vertical tick
// until the accumulator is no longer negative.
// ----------------------------------------------------------------------------
module tnsg_rate_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tnsg_pkg::RATE_W-1:0] out_rate_i,
  output logic                        idle_o,
  output logic                        tick_o
);
  import tnsg_pkg::*;

  localparam logic signed [ACC_W-1:0] NEG_VCLOCK = ACC_W'(-VCLOCK_RATE);

  tnsg_state_e              state_q, state_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  operand;
  logic signed [ACC_W-1:0]  sum;
  logic [RATE_W-1:0]        rate_eff;

  // Clamp small rates
  assign rate_eff = (out_rate_i < RATE_W'(MIN_RATE)) ? RATE_W'(MIN_RATE) : out_rate_i;

  // Shared adder
  assign operand = (state_q == ST_SUB) ? NEG_VCLOCK
                                       : $signed({{(ACC_W-RATE_W){1'b0}}, rate_eff});
  assign sum     = acc_q + operand;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // Step through subtract, then ticks while negative
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    idle_o  = 1'b0;
    tick_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        acc_d   = sum;
        state_d = sum[ACC_W-1] ? ST_TICK : ST_IDLE;
      end
      ST_TICK: begin
        tick_o  = 1'b1;
        acc_d   = sum;
        state_d = sum[ACC_W-1] ? ST_TICK : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/tone_noise_sound_generator.sv
// A sample appears in the output register in the cycle after its request
// transaction. A sample request keeps the block busy through the subtract
// state and the N vertical ticks it triggers (0..12), one tick per cycle from
// the shared accumulator adder; a latch write leaves the sequencer idle.
// Reset clears all but sample_q, sets the rate to 48000; no clearing pass.
// ----------------------------------------------------------------------------
// tone_noise_sound_generator
// Tone and noise sound generator with sound latch, decaying volume and
// vertical clock to sample rate conversion.
// ----------------------------------------------------------------------------
module tone_noise_sound_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  tnsg_req_if.sink   req_i,
  tnsg_smp_if.source smp_o,
  tnsg_cfg_if.sink   cfg_i
);
  import tnsg_pkg::*;

  `include "tone_noise_sound_generator_assert.svh"

  logic [RATE_W-1:0]   out_rate_q;
  logic                smp_valid_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                seq_idle;
  logic                seq_tick;
  logic                req_acc;
  logic                smp_req;
  tnsg_voice_ctrl_t    vctrl;
  tnsg_voice_stat_t    vstat;

  // Accept only when idle and the output register can take a result
  assign req_i.ready = seq_idle && (!smp_valid_q || smp_o.ready);
  assign req_acc     = req_i.valid && req_i.ready;
  assign smp_req     = req_acc && (req_i.mode == MODE_SAMPLE);

  // Hold the sample rate register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_rate_q <= RATE_W'(OUT_RATE_RST);
    end else if (cfg_i.valid && cfg_i.ready) begin
      out_rate_q <= cfg_i.out_rate;
    end
  end

  tnsg_rate_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (smp_req),
    .out_rate_i (out_rate_q),
    .idle_o     (seq_idle),
    .tick_o     (seq_tick)
  );

  assign vctrl.latch_we   = req_acc && (req_i.mode == MODE_LATCH);
  assign vctrl.latch_data = req_i.latch_data;
  assign vctrl.tick       = seq_tick;

  tnsg_voice u_voice (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (vctrl),
    .stat_o (vstat)
  );

  // Capture the current signal on a sample request, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (smp_req) begin
      smp_valid_q <= 1'b1;
    end else if (smp_o.ready) begin
      smp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_req) begin
      sample_q <= vstat.halve ? (vstat.signal_level >> 1) : vstat.signal_level;
    end
  end

  assign smp_o.valid  = smp_valid_q;
  assign smp_o.sample = sample_q;

  // Checks
  `TNSG_ASSERT_SAME(a_no_overwrite, req_acc, !smp_valid_q || smp_o.ready)
  `TNSG_ASSERT_SAME(a_tick_busy, seq_tick, !req_i.ready && !vctrl.latch_we)
  `TNSG_ASSERT_NEXT(a_req_result, smp_req, smp_valid_q && !seq_idle)

endmodule

FILE: tb/tb_tone_noise_sound_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_noise_sound_generator
// Self-checking bench for the tone and noise sound generator. A directed
// table covers the waveforms, the halving bit and the rate extremes. Random
// phases at several sample rates follow, mostly latch writes with sample
// runs behind them. Every sample is checked against a cycle-free model of
// the generator state or, where a directed row gives one, a typed-in value.
// ----------------------------------------------------------------------------
module tb_tone_noise_sound_generator;
  import tnsg_pkg::*;

  localparam int DRAIN_CYCLES = 16;

  typedef enum logic {
    ROW_ITEM,
    ROW_RATE
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic                mode;
    logic [LATCH_W-1:0]  data;
    logic [RATE_W-1:0]   rate;
    logic                typed;
    logic [SAMPLE_W-1:0] want;
  } dir_row_t;

  // Directed rows; expected samples typed in only where they are obvious
  localparam dir_row_t DIR_ROWS [33] = '{
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b1, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'hff, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b1, 15'd0},
    '{ROW_RATE, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'hff, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'h09, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'h12, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'h1b, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'h24, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'h2d, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'hf6, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_LATCH,  8'h87, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'hff, 18'd0,      1'b0, 15'd0},
    '{ROW_RATE, MODE_SAMPLE, 8'h00, 18'd999,    1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_RATE, MODE_SAMPLE, 8'h00, 18'd262143, 1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_RATE, MODE_SAMPLE, 8'h00, 18'd1000,   1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_RATE, MODE_SAMPLE, 8'h00, 18'd192000, 1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0},
    '{ROW_ITEM, MODE_SAMPLE, 8'h00, 18'd0,      1'b0, 15'd0}
  };

  logic clk_i;
  logic rst_ni;

  tnsg_req_if req_if ();
  tnsg_smp_if smp_if ();
  tnsg_cfg_if cfg_if ();

  tone_noise_sound_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .smp_o  (smp_if),
    .cfg_i  (cfg_if)
  );

  // Generator model state
  logic [LATCH_W-1:0]  gen_latch;
  logic [SAMPLE_W-1:0] gen_signal;
  logic [SAMPLE_W-1:0] gen_volume;
  logic [NOISE_W-1:0]  gen_noise;
  int                  gen_acc;
  logic [VCOUNT_W-1:0] gen_vcount;
  logic [RATE_W-1:0]   gen_rate;

  logic [SAMPLE_W-1:0] sample_due [$];
  int unsigned         mismatches;
  bit                  steady_flow;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic int unsigned idle_draw();
    return steady_flow ? 0 : $urandom_range(0, 3);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Apply one transaction to the model; return 1 when it emits a sample
  function automatic bit advance_generator(input logic m, input logic [LATCH_W-1:0] d,
                                           output logic [SAMPLE_W-1:0] smp);
    int               eff_rate;
    logic             on;
    logic             fb;
    logic [VCOUNT_W-1:0] v;
    smp = '0;
    if (m == MODE_LATCH) begin
      gen_latch  = d;
      gen_volume = FULL_VOLUME;
      gen_noise  = '0;
      return 1'b0;
    end
    smp = gen_latch[3] ? (gen_signal >> 1) : gen_signal;
    // Clamp low rates so a sample never triggers more than twelve ticks
    eff_rate = (gen_rate < MIN_RATE) ? MIN_RATE : int'(gen_rate);
    gen_acc -= VCLOCK_RATE;
    while (gen_acc < 0) begin
      gen_acc += eff_rate;
      gen_vcount = gen_vcount + 1'b1;
      v = gen_vcount;
      case (tnsg_wave_e'(gen_latch[2:0]))
        WAVE_SQ_V2:   on = v[2];
        WAVE_SQ_V3:   on = v[3];
        WAVE_SQ_V4:   on = v[4];
        WAVE_SQ_V5:   on = v[5];
        WAVE_MIX_V04: on = !v[0] && !v[4];
        WAVE_MIX_V15: on = !v[1] && !v[5];
        WAVE_MIX_V26: on = !v[2] && !v[6];
        default: begin
          // Noise: output the shifter top bit, clock it on count phase two
          on = gen_noise[NOISE_W-1];
          if (v[1:0] == 2'b10) begin
            fb = (gen_noise[0] == gen_noise[10]);
            gen_noise = {gen_noise[NOISE_W-2:0], fb};
          end
        end
      endcase
      gen_signal = on ? gen_volume : '0;
      gen_volume = (gen_volume > VOLUME_STEP) ? gen_volume - VOLUME_STEP : '0;
    end
    return 1'b1;
  endfunction

  // Send one request transaction; called and returns just after a falling edge
  task automatic send_item(input logic m, input logic [LATCH_W-1:0] d,
                           input bit typed, input logic [SAMPLE_W-1:0] want);
    int unsigned         gap;
    logic [SAMPLE_W-1:0] smp;
    gap = idle_draw();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= m;
    req_if.latch_data <= d;
    do @(posedge clk_i); while (!req_if.ready);
    if (advance_generator(m, d, smp))
      sample_due.push_back(typed ? want : smp);
    @(negedge clk_i);
  endtask

  // Write the sample rate once the block has drained
  task automatic write_rate(input logic [RATE_W-1:0] rate);
    req_if.valid <= 1'b0;
    while (sample_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.out_rate <= rate;
    do @(posedge clk_i); while (!cfg_if.ready);
    gen_rate = rate;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Sample sink: stall at random before each transaction, except in steady flow
  initial begin : sample_sink
    int unsigned stall;
    smp_if.ready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        smp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      smp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(smp_if.valid && smp_if.ready));
      @(negedge clk_i);
    end
  end

  // Compare each accepted sample with the oldest expectation
  always @(posedge clk_i) begin : sample_check
    logic [SAMPLE_W-1:0] want;
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      if (sample_due.size() == 0) begin
        report_mismatch($sformatf("unexpected sample 0x%04h", smp_if.sample));
      end else begin
        want = sample_due.pop_front();
        if (smp_if.sample !== want)
          report_mismatch($sformatf("sample 0x%04h, want 0x%04h", smp_if.sample, want));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [RATE_W-1:0] rate;
    int unsigned       sent;
    int unsigned       run;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_SAMPLE;
    req_if.latch_data  = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.out_rate    = '0;
    mismatches         = 0;
    steady_flow        = 1'b0;
    gen_latch          = '0;
    gen_signal         = '0;
    gen_volume         = '0;
    gen_noise          = '0;
    gen_acc            = 0;
    gen_vcount         = '0;
    gen_rate           = RATE_W'(OUT_RATE_RST);
    wait (rst_ni);
    @(negedge clk_i);

    // Walk the directed table
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_RATE)
        write_rate(DIR_ROWS[i].rate);
      else
        send_item(DIR_ROWS[i].mode, DIR_ROWS[i].data, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    // Random phases, one sample rate each
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       rate = 18'd12000;
        1:       rate = 18'd44100;
        2:       rate = 18'd0;
        3:       rate = 18'd192000;
        4:       rate = 18'd999;
        5:       rate = 18'd262143;
        6:       rate = 18'd1000;
        7:       rate = 18'd48000;
        8:       rate = RATE_W'($urandom_range(1000, 192000));
        default: rate = RATE_W'($urandom_range(0, 262143));
      endcase
      write_rate(rate);
      if (ph == 2) begin
        // One latch write, then a long run of samples: let the volume decay to zero
        steady_flow = 1'b0;
        send_item(MODE_LATCH, LATCH_W'($urandom), 1'b0, '0);
        repeat (380) send_item(MODE_SAMPLE, LATCH_W'($urandom), 1'b0, '0);
      end else begin
        sent = 0;
        while (sent < 80) begin
          steady_flow = ($urandom_range(0, 3) == 0);
          if ($urandom_range(0, 6) != 0) begin
            // Latch write followed by a run of sample requests
            run = $urandom_range(1, 16);
            send_item(MODE_LATCH, LATCH_W'($urandom), 1'b0, '0);
            repeat (run) send_item(MODE_SAMPLE, LATCH_W'($urandom), 1'b0, '0);
            sent += run + 1;
          end else begin
            send_item(1'($urandom), LATCH_W'($urandom), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    // Drain and finish
    req_if.valid <= 1'b0;
    while (sample_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
